// ----- src/pcpg_pkg.sv -----
// Shared types and constants for the positive-negative circle point generator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pcpg_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = RADIUS_BITS + 1;
  localparam int DIFF_BITS   = 2 * RADIUS_BITS + 2;
  localparam int IDX_BITS    = 3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  localparam logic [IDX_BITS-1:0] IDX_FIRST = 3'd0;
  localparam logic [IDX_BITS-1:0] IDX_LAST  = 3'd7;

  typedef struct packed {
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic                   fin;
    logic [IDX_BITS-1:0]    first_idx;
  } desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

// ----- src/pcpg_front.sv -----
// Front end: accepts commands, keeps the current point and the running error
// term, and turns each next command into a point group descriptor. Uses pcpg_pkg.
`timescale 1ns / 1ps

module pcpg_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             command,
  input  logic [pcpg_pkg::RADIUS_BITS-1:0] radius,
  output logic                             enq,
  output pcpg_pkg::desc_t                  desc
);

  logic                                   active;
  logic [pcpg_pkg::COORD_BITS-1:0]        cur_x;
  logic [pcpg_pkg::COORD_BITS-1:0]        cur_y;
  logic signed [pcpg_pkg::DIFF_BITS-1:0]  diff;

  logic [pcpg_pkg::COORD_BITS-1:0]        cur_x_next;
  logic [pcpg_pkg::COORD_BITS-1:0]        cur_y_next;
  logic signed [pcpg_pkg::DIFF_BITS-1:0]  diff_next;
  logic signed [pcpg_pkg::DIFF_BITS-1:0]  x_ext;
  logic signed [pcpg_pkg::DIFF_BITS-1:0]  y_ext;
  logic                                   outside;
  logic                                   fin;

  always_comb begin
    x_ext   = signed'({{(pcpg_pkg::DIFF_BITS - pcpg_pkg::COORD_BITS){1'b0}}, cur_x});
    y_ext   = signed'({{(pcpg_pkg::DIFF_BITS - pcpg_pkg::COORD_BITS){1'b0}}, cur_y});
    outside = !diff[pcpg_pkg::DIFF_BITS-1] && (diff != '0);
    if (outside) begin
      cur_x_next = cur_x;
      cur_y_next = cur_y - {{(pcpg_pkg::COORD_BITS-1){1'b0}}, 1'b1};
      diff_next  = diff - (y_ext <<< 1) + signed'({{(pcpg_pkg::DIFF_BITS-1){1'b0}}, 1'b1});
    end else begin
      cur_x_next = cur_x + {{(pcpg_pkg::COORD_BITS-1){1'b0}}, 1'b1};
      cur_y_next = cur_y;
      diff_next  = diff + (x_ext <<< 1) + signed'({{(pcpg_pkg::DIFF_BITS-1){1'b0}}, 1'b1});
    end
    fin = cur_x_next > cur_y_next;
  end

  always_comb begin
    enq = accept && (command == pcpg_pkg::CMD_NEXT);
    if (active) begin
      desc.x         = cur_x[pcpg_pkg::RADIUS_BITS-1:0];
      desc.y         = cur_y[pcpg_pkg::RADIUS_BITS-1:0];
      desc.fin       = fin;
      desc.first_idx = pcpg_pkg::IDX_FIRST;
    end else begin
      desc.x         = '0;
      desc.y         = '0;
      desc.fin       = 1'b1;
      desc.first_idx = pcpg_pkg::IDX_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cur_x  <= '0;
      cur_y  <= '0;
      diff   <= '0;
    end else if (accept) begin
      if (command == pcpg_pkg::CMD_START) begin
        active <= 1'b1;
        cur_x  <= '0;
        cur_y  <= {1'b0, radius};
        diff   <= '0;
      end else if (active) begin
        cur_x <= cur_x_next;
        cur_y <= cur_y_next;
        diff  <= diff_next;
        if (fin) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/pcpg_queue.sv -----
// Two-entry descriptor queue between the front end and the point emitter.
// Uses pcpg_pkg.
`timescale 1ns / 1ps

module pcpg_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     enq,
  input  pcpg_pkg::desc_t          enq_desc,
  input  logic                     deq,
  output pcpg_pkg::desc_t          deq_desc,
  output pcpg_pkg::queue_status_t  status
);

  pcpg_pkg::desc_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  always_comb begin
    status.full  = count == 2'd2;
    status.valid = count != 2'd0;
    deq_desc     = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      entries[wr_ptr] <= enq_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      if (enq && !deq) begin
        count <= count + 2'd1;
      end else if (deq && !enq) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- src/pcpg_back.sv -----
// Back end: expands each descriptor into its mirrored points, one beat per
// cycle while the result is empty or being popped, into the result register. Uses pcpg_pkg.
`timescale 1ns / 1ps

module pcpg_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  pcpg_pkg::desc_t                        q_desc,
  output logic                                   q_deq,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [pcpg_pkg::COORD_BITS-1:0] px,
  output logic signed [pcpg_pkg::COORD_BITS-1:0] py,
  output logic                                   last,
  output logic                                   finished,
  output logic                                   busy
);

  pcpg_pkg::desc_t                 cur;
  logic                            cur_valid;
  logic [pcpg_pkg::IDX_BITS-1:0]   idx;
  logic                            out_valid;

  logic                            advance;
  logic                            at_last;
  logic [pcpg_pkg::COORD_BITS-1:0] a_ext;
  logic [pcpg_pkg::COORD_BITS-1:0] b_ext;
  logic [pcpg_pkg::COORD_BITS-1:0] px_next;
  logic [pcpg_pkg::COORD_BITS-1:0] py_next;

  always_comb begin
    at_last = idx == pcpg_pkg::IDX_LAST;
    advance = cur_valid && (!out_valid || pop);
    q_deq   = q_valid && (!cur_valid || (advance && at_last));
    if (idx[2]) begin
      a_ext = {1'b0, cur.y};
      b_ext = {1'b0, cur.x};
    end else begin
      a_ext = {1'b0, cur.x};
      b_ext = {1'b0, cur.y};
    end
    px_next = idx[0] ? (-a_ext) : a_ext;
    py_next = idx[1] ? (-b_ext) : b_ext;
    empty   = !out_valid;
    busy    = cur_valid;
  end

  always_ff @(posedge clk) begin
    if (q_deq) begin
      cur <= q_desc;
    end
    if (advance) begin
      px       <= signed'(px_next);
      py       <= signed'(py_next);
      last     <= at_last;
      finished <= cur.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_deq) begin
        cur_valid <= 1'b1;
        idx       <= q_desc.first_idx;
      end else if (advance) begin
        idx <= idx + {{(pcpg_pkg::IDX_BITS-1){1'b0}}, 1'b1};
        if (at_last) begin
          cur_valid <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/pn_circle_point_generator.sv -----
// Top level of the positive-negative circle point generator.
// Instantiates pcpg_front, pcpg_queue and pcpg_back; uses pcpg_pkg.
`timescale 1ns / 1ps

// The block takes one command beat per cycle as long as full is low. A start
// beat loads the radius and yields no result; a next beat yields the eight
// mirrored points of the current position, or a single zero point flagged
// last and finished when no circle is in progress. The front end steps the
// circle with an add-and-compare on a running error term, so it never needs
// a multiplier, and hands a descriptor to a two-entry queue. The back end
// writes one point per cycle into the result register while the result is
// empty or being popped.
module pn_circle_point_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   command,
  input  logic [pcpg_pkg::RADIUS_BITS-1:0]       radius,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [pcpg_pkg::COORD_BITS-1:0] px,
  output logic signed [pcpg_pkg::COORD_BITS-1:0] py,
  output logic                                   last,
  output logic                                   finished
);

  logic                    accept;
  logic                    enq;
  logic                    deq;
  logic                    back_busy;
  pcpg_pkg::desc_t         enq_desc;
  pcpg_pkg::desc_t         deq_desc;
  pcpg_pkg::queue_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  pcpg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .radius  (radius),
    .enq     (enq),
    .desc    (enq_desc)
  );

  pcpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .enq_desc (enq_desc),
    .deq      (deq),
    .deq_desc (deq_desc),
    .status   (q_status)
  );

  pcpg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_status.valid),
    .q_desc   (deq_desc),
    .q_deq    (deq),
    .pop      (pop),
    .empty    (empty),
    .px       (px),
    .py       (py),
    .last     (last),
    .finished (finished),
    .busy     (back_busy)
  );

  // A waiting point that does not close its group implies the rest of the
  // group is still held by the back end.
  a_group_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> back_busy)
    else $error("Non-last point waiting without a group in the back end.");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq |-> !q_status.full)
    else $error("Descriptor queued while the queue is full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    deq |-> q_status.valid)
    else $error("Descriptor taken from an empty queue.");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ($fell(empty) && !$past(rst)) |-> $past(back_busy))
    else $error("Result appeared without an active group.");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for pn_circle_point_generator.
// It predicts every point group in a small tracker class and compares each result beat.
// It depends on pcpg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 195;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;

  typedef logic signed [pcpg_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   last;
    logic   finished;
  } point_t;

  class circle_tracker;
    coord_t                             pos_x;
    coord_t                             pos_y;
    logic [2*pcpg_pkg::RADIUS_BITS-1:0] r_sq;
    bit                                 circle_on;
    point_t                             expected_points[$];
    int                                 errors;
    int                                 points_checked;
    int                                 circles_done;
    int                                 commands_seen;

    function new();
      pos_x = '0;
      pos_y = '0;
      r_sq = '0;
      circle_on = 1'b0;
      errors = 0;
      points_checked = 0;
      circles_done = 0;
      commands_seen = 0;
    endfunction

    function void add_point(coord_t x, coord_t y, logic lst, logic fin);
      point_t p;
      p.px = x;
      p.py = y;
      p.last = lst;
      p.finished = fin;
      expected_points.push_back(p);
    endfunction

    function void note_command(logic cmd, logic [pcpg_pkg::RADIUS_BITS-1:0] rad);
      longint unsigned dist_sq;
      coord_t x;
      coord_t y;
      logic fin;
      commands_seen++;
      if (cmd == pcpg_pkg::CMD_START) begin
        pos_x = '0;
        pos_y = {1'b0, rad};
        r_sq = {{pcpg_pkg::RADIUS_BITS{1'b0}}, rad} * {{pcpg_pkg::RADIUS_BITS{1'b0}}, rad};
        circle_on = 1'b1;
        return;
      end
      if (!circle_on) begin
        add_point('0, '0, 1'b1, 1'b1);
        return;
      end
      x = pos_x;
      y = pos_y;
      dist_sq = longint'(x) * longint'(x) + longint'(y) * longint'(y);
      if (dist_sq > longint'(r_sq)) begin
        pos_y = y - coord_t'(1);
      end else begin
        pos_x = x + coord_t'(1);
      end
      fin = (pos_x > pos_y);
      if (fin) begin
        circle_on = 1'b0;
        circles_done++;
      end
      add_point(x, y, 1'b0, fin);
      add_point(-x, y, 1'b0, fin);
      add_point(x, -y, 1'b0, fin);
      add_point(-x, -y, 1'b0, fin);
      add_point(y, x, 1'b0, fin);
      add_point(-y, x, 1'b0, fin);
      add_point(y, -x, 1'b0, fin);
      add_point(-y, -x, 1'b1, fin);
    endfunction

    function void check_point(coord_t x, coord_t y, logic lst, logic fin);
      point_t p;
      points_checked++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result beat px=%0d py=%0d last=%0b finished=%0b",
                 $time, x, y, lst, fin);
        errors++;
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.px) begin
        $display("%0t: px expected %0d actual %0d", $time, p.px, x);
        errors++;
      end
      if (y !== p.py) begin
        $display("%0t: py expected %0d actual %0d", $time, p.py, y);
        errors++;
      end
      if (lst !== p.last) begin
        $display("%0t: last expected %0b actual %0b", $time, p.last, lst);
        errors++;
      end
      if (fin !== p.finished) begin
        $display("%0t: finished expected %0b actual %0b", $time, p.finished, fin);
        errors++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             command = pcpg_pkg::CMD_START;
  logic [pcpg_pkg::RADIUS_BITS-1:0] radius = '0;
  logic                             pop = 1'b0;
  logic                             full;
  logic                             empty;
  coord_t                           px;
  coord_t                           py;
  logic                             last;
  logic                             finished;

  circle_tracker tracker = new();
  bit            steady_push = 1'b0;
  bit            steady_pop = 1'b0;
  int            quiet_cycles = 0;
  int            random_items = 0;

  pn_circle_point_generator dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .command  (command),
    .radius   (radius),
    .empty    (empty),
    .pop      (pop),
    .px       (px),
    .py       (py),
    .last     (last),
    .finished (finished)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (pop && !empty) begin
        tracker.check_point(px, py, last, finished);
      end
      pop <= steady_pop ? 1'b1 : ($urandom_range(99) >= 22);
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [pcpg_pkg::RADIUS_BITS-1:0] rad);
    while (!steady_push && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    command <= cmd;
    radius <= rad;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    tracker.note_command(cmd, rad);
  endtask

  task automatic trace_circle(input int max_steps);
    int steps;
    steps = 0;
    while (tracker.circle_on && steps < max_steps) begin
      send_beat(pcpg_pkg::CMD_NEXT, pcpg_pkg::RADIUS_BITS'($urandom));
      steps++;
      random_items++;
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [pcpg_pkg::RADIUS_BITS-1:0] pick_radius();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) begin
      return pcpg_pkg::RADIUS_BITS'($urandom_range(15));
    end else if (roll < 92) begin
      return pcpg_pkg::RADIUS_BITS'($urandom_range(60, 16));
    end
    return pcpg_pkg::RADIUS_BITS'($urandom);
  endfunction

  initial begin
    logic [pcpg_pkg::RADIUS_BITS-1:0] rad;
    int roll;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_beat(pcpg_pkg::CMD_NEXT, '0);
    send_beat(pcpg_pkg::CMD_START, '0);
    send_beat(pcpg_pkg::CMD_NEXT, '1);
    send_beat(pcpg_pkg::CMD_NEXT, '0);
    send_beat(pcpg_pkg::CMD_START, '1);
    repeat (3) send_beat(pcpg_pkg::CMD_NEXT, '0);
    send_beat(pcpg_pkg::CMD_START, pcpg_pkg::RADIUS_BITS'(1));
    trace_circle(10);
    send_beat(pcpg_pkg::CMD_NEXT, '1);
    send_beat(pcpg_pkg::CMD_START, pcpg_pkg::RADIUS_BITS'(7));
    trace_circle(20);
    send_beat(pcpg_pkg::CMD_NEXT, '0);
    wait_drained();
    random_items = 0;

    while (random_items < RANDOM_ITEMS) begin
      steady_push = (random_items >= 80 && random_items < 140);
      steady_pop = steady_push;
      roll = $urandom_range(99);
      if (roll < 10) begin
        send_beat(logic'($urandom_range(1)), pcpg_pkg::RADIUS_BITS'($urandom));
        random_items++;
      end else begin
        rad = pick_radius();
        send_beat(pcpg_pkg::CMD_START, rad);
        random_items++;
        if (rad > 60 || $urandom_range(99) < 15) begin
          trace_circle($urandom_range(6, 1));
        end else begin
          trace_circle(1000);
          if ($urandom_range(99) < 30) begin
            send_beat(pcpg_pkg::CMD_NEXT, pcpg_pkg::RADIUS_BITS'($urandom));
            random_items++;
          end
        end
      end
      if (random_items >= 150 && random_items < 160) begin
        wait_drained();
      end
    end

    steady_push = 1'b0;
    steady_pop = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    $display("Run covered %0d command beats, %0d result beats checked, %0d circles traced.",
             tracker.commands_seen, tracker.points_checked, tracker.circles_done);
    $display("Idle next beats, abandoned circles and radii from 0 to 1023 were exercised.");
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pcpg_pkg.sv
src/pcpg_front.sv
src/pcpg_queue.sv
src/pcpg_back.sv
src/pn_circle_point_generator.sv
tb/sv/testbench.sv
